// ===== hdl/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and codes for the selective-repeat receiver window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  // result kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

endpackage

// ===== hdl/srrw_mem.sv =====
// ----------------------------------------------------------------------------
// srrw_mem
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrw_mem #(
  parameter int Depth = 8,
  parameter int AddrW = 3,
  parameter int DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== hdl/selective_repeat_receiver_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_window
// Receiver side of selective-repeat ARQ with an in-order delivery sequencer.
// ----------------------------------------------------------------------------
// Each accepted item is one arriving packet. A packet with a bad checksum, an
// out-of-range sequence number, or a number outside both the receive window and
// the previous window is consumed with no result. Otherwise the acknowledgement
// is produced the cycle after acceptance. When the packet hits the window base,
// the sequencer reads the payload buffer in ST_READ and then, in ST_EMIT,
// delivers one payload per cycle while the result register is not stalled, up
// to min(WINDOW, SEQ_COUNT) payloads per packet; the single read port of the
// payload buffer sets that pace. Input is stalled while deliveries are in
// flight and while the result register is full and stalled. Held flags clear
// at reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_window #(
  parameter int SEQ_COUNT    = 8,
  parameter int WINDOW       = 4,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [$clog2(SEQ_COUNT)-1:0] seq_num_i,
  input  logic                         checksum_ok_i,
  input  logic [PAYLOAD_BITS-1:0]      payload_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [$clog2(SEQ_COUNT)-1:0] number_o,
  output logic [PAYLOAD_BITS-1:0]      data_o,
  output logic                         last_o
);

  localparam int SW    = $clog2(SEQ_COUNT);
  localparam int LIMIT = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
  localparam int CW    = $clog2(LIMIT + 1);

  srrw_pkg::state_e state_q, state_d;

  logic [SW-1:0]           base_q, base_d;
  logic [SW-1:0]           slot_q, slot_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [SEQ_COUNT-1:0]    held_q, held_d;

  logic                    out_valid_q, out_valid_d;
  logic                    kind_q, kind_d;
  logic [SW-1:0]           number_q, number_d;
  logic [PAYLOAD_BITS-1:0] data_q, data_d;
  logic                    last_q, last_d;

  logic                    out_free;
  logic                    accept;
  logic                    out_load;
  logic                    mem_we;
  logic [SW-1:0]           rd_addr;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic [SW-1:0]           next_slot;
  logic                    more;

  logic [SW:0]             diff_ahead, diff_behind;
  logic [SW-1:0]           ahead, behind;
  logic                    in_range, in_win, prev_win, is_base, good;

  // window classification of the arriving packet
  always_comb begin
    diff_ahead  = {1'b0, seq_num_i} - {1'b0, base_q};
    diff_behind = {1'b0, base_q} - {1'b0, seq_num_i};
    ahead  = diff_ahead[SW]  ? SW'(diff_ahead  + (SW+1)'(SEQ_COUNT)) : diff_ahead[SW-1:0];
    behind = diff_behind[SW] ? SW'(diff_behind + (SW+1)'(SEQ_COUNT)) : diff_behind[SW-1:0];
    in_range = (SW+1)'(seq_num_i) < (SW+1)'(SEQ_COUNT);
    in_win   = in_range && (32'(ahead) < 32'(WINDOW));
    prev_win = in_range && !in_win && (behind != '0) && (32'(behind) <= 32'(WINDOW));
    is_base  = (seq_num_i == base_q);
  end

  // delivery walk helpers
  always_comb begin
    next_slot = (32'(slot_q) == SEQ_COUNT - 1) ? '0 : SW'(slot_q + 1'b1);
    more      = held_q[next_slot] && ((32'(cnt_q) + 32'd1) < 32'(LIMIT));
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign good     = accept && checksum_ok_i && (in_win || prev_win);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srrw_pkg::ST_IDLE: begin
        if (good && in_win && is_base) state_d = srrw_pkg::ST_READ;
      end
      srrw_pkg::ST_READ: begin
        state_d = srrw_pkg::ST_EMIT;
      end
      srrw_pkg::ST_EMIT: begin
        if (out_free && !more) state_d = srrw_pkg::ST_IDLE;
      end
      default: state_d = srrw_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = slot_q;
    kind_d     = kind_q;
    number_d   = number_q;
    data_d     = data_q;
    last_d     = last_q;
    unique case (state_q)
      srrw_pkg::ST_IDLE: begin
        in_stall_o = !out_free;
        out_load   = good;
        mem_we     = accept && checksum_ok_i && in_win && !held_q[seq_num_i];
        kind_d     = srrw_pkg::KIND_ACK;
        number_d   = seq_num_i;
        data_d     = '0;
        last_d     = !(in_win && is_base);
      end
      srrw_pkg::ST_READ: begin
        rd_addr = slot_q;
      end
      srrw_pkg::ST_EMIT: begin
        out_load = out_free;
        rd_addr  = out_free ? next_slot : slot_q;
        kind_d   = srrw_pkg::KIND_DATA;
        number_d = slot_q;
        data_d   = rd_data;
        last_d   = !more;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // window state updates
  always_comb begin
    held_d = held_q;
    base_d = base_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (state_q == srrw_pkg::ST_IDLE && good && in_win) begin
      held_d[seq_num_i] = 1'b1;
      slot_d = base_q;
      cnt_d  = '0;
    end else if (state_q == srrw_pkg::ST_EMIT && out_load) begin
      held_d[slot_q] = 1'b0;
      slot_d = next_slot;
      base_d = next_slot;
      cnt_d  = CW'(cnt_q + 1'b1);
    end
  end

  // result register valid
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srrw_pkg::ST_IDLE;
      base_q      <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= kind_d;
      number_q <= number_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  // payload buffer
  srrw_mem #(
    .Depth (SEQ_COUNT),
    .AddrW (SW),
    .DataW (PAYLOAD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (seq_num_i),
    .wr_data_i (payload_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign number_o    = number_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  // a delivered slot must be held
  a_deliver_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srrw_pkg::ST_EMIT && out_load) |-> held_q[slot_q])
    else $error("delivery from a slot that is not held");

  // the base moves only on a delivery
  a_base_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == srrw_pkg::ST_EMIT && out_load) |=> $stable(base_q))
    else $error("window base moved without a delivery");

  // deliveries per packet stay within the window
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srrw_pkg::ST_EMIT) |-> (32'(cnt_q) < 32'(LIMIT)))
    else $error("too many deliveries for one packet");

  // no packet is taken while deliveries are pending
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != srrw_pkg::ST_IDLE) |-> !accept)
    else $error("packet accepted during delivery");
`endif

endmodule

// ===== bench/selective_repeat_receiver_window_tb.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_window_tb
// Self-checking bench for the selective-repeat receiver window. A directed
// table of packets walks reset, corrupted packets, re-acks of the previous
// window, duplicates and full in-order flushes with wrap-around. A random
// stream of mostly in-window packets follows. A local window tracker predicts
// every ack and delivery. Input bursts and output stalls are random, and one
// long output hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_window_tb;

  localparam int SEQ_COUNT    = 8;
  localparam int WINDOW       = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_W        = $clog2(SEQ_COUNT);
  localparam int MAX_FLUSH    = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
  localparam int MAX_RES      = 1 + MAX_FLUSH;
  localparam int RAND_PKTS    = 270;
  localparam int N_DIR        = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  // how a table row is checked
  typedef enum logic [1:0] {
    EXP_PREDICTED,
    EXP_NONE,
    EXP_ACK,
    EXP_ACK_DLV
  } row_exp_e;

  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic                    ok;
    logic [PAYLOAD_BITS-1:0] payload;
    row_exp_e                mode;
  } pkt_row_t;

  typedef struct packed {
    logic                    kind;
    logic [SEQ_W-1:0]        number;
    logic [PAYLOAD_BITS-1:0] data;
    logic                    last;
  } rx_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [SEQ_W-1:0]        seq_num_i     = '0;
  logic                    checksum_ok_i = 1'b0;
  logic [PAYLOAD_BITS-1:0] payload_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    kind_o;
  logic [SEQ_W-1:0]        number_o;
  logic [PAYLOAD_BITS-1:0] data_o;
  logic                    last_o;

  // window tracker state
  int unsigned             win_base;
  bit                      slot_held [SEQ_COUNT];
  logic [PAYLOAD_BITS-1:0] slot_data [SEQ_COUNT];

  rx_result_t  due_results[$];
  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 1;
  int unsigned cycle_cnt    = 0;

  pkt_row_t dir_rows [N_DIR];

  selective_repeat_receiver_window #(
    .SEQ_COUNT    (SEQ_COUNT),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .number_o      (number_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ack / delivery prediction for one accepted packet, updates the window
  function automatic void predict_window_results(
    input  logic [SEQ_W-1:0]        seq,
    input  logic                    ok,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output rx_result_t              res [MAX_RES],
    output int                      n
  );
    int unsigned s, ahead, behind, slot, k;
    n = 0;
    for (k = 0; k < MAX_RES; k++) res[k] = '0;
    if (!ok) return;
    s      = 32'(seq);
    ahead  = (s + SEQ_COUNT - win_base) % SEQ_COUNT;
    behind = (win_base + SEQ_COUNT - s) % SEQ_COUNT;
    if (ahead < WINDOW) begin
      res[n] = '{srrw_pkg::KIND_ACK, seq, '0, 1'b0};
      n = n + 1;
      // first copy of a payload wins
      if (!slot_held[s]) begin
        slot_data[s] = payload;
        slot_held[s] = 1'b1;
      end
      // flush in order up to the first gap
      if (s == win_base) begin
        slot = win_base;
        for (k = 0; k < MAX_FLUSH; k++) begin
          if (!slot_held[slot]) break;
          res[n] = '{srrw_pkg::KIND_DATA, SEQ_W'(slot), slot_data[slot], 1'b0};
          n = n + 1;
          slot_held[slot] = 1'b0;
          slot = (slot + 1) % SEQ_COUNT;
        end
        win_base = slot;
      end
    end else if (behind >= 1 && behind <= WINDOW) begin
      res[n] = '{srrw_pkg::KIND_ACK, seq, '0, 1'b0};
      n = n + 1;
    end
    if (n > 0) res[n-1].last = 1'b1;
  endfunction

  // drop valid to leave a gap between bursts
  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // offer one packet, wait for it to be taken, queue what it should cause
  task automatic offer_packet(
    input logic [SEQ_W-1:0]        seq,
    input logic                    ok,
    input logic [PAYLOAD_BITS-1:0] payload,
    input row_exp_e                mode
  );
    rx_result_t res [MAX_RES];
    int         n, k;
    in_valid_i    <= 1'b1;
    seq_num_i     <= seq;
    checksum_ok_i <= ok;
    payload_i     <= payload;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_window_results(seq, ok, payload, res, n);
    case (mode)
      EXP_PREDICTED: for (k = 0; k < n; k++) due_results.push_back(res[k]);
      EXP_NONE: ;
      EXP_ACK: due_results.push_back('{srrw_pkg::KIND_ACK, seq, '0, 1'b1});
      EXP_ACK_DLV: begin
        due_results.push_back('{srrw_pkg::KIND_ACK, seq, '0, 1'b0});
        due_results.push_back('{srrw_pkg::KIND_DATA, seq, payload, 1'b1});
      end
    endcase
    // sender bursts with gaps between them
    burst_left--;
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : rx_check
    rx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("unexpected item: kind %0d number %0d data %h last %0d",
               kind_o, number_o, data_o, last_o);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fail_cnt++;
        end
        if (number_o !== want.number) begin
          $error("number: expected %0d, got %0d", want.number, number_o);
          fail_cnt++;
        end
        if (data_o !== want.data) begin
          $error("data: expected %h, got %h", want.data, data_o);
          fail_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // output stall pattern, with one long hold-off to back the block up
  initial begin : rx_stall
    bit          held_off;
    int unsigned mode, len;
    logic        s;
    held_off = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && results_seen >= 40) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(4, 40);
        repeat (len) begin
          case (mode)
            0:       s = 1'b0;
            1:       s = 1'($urandom_range(0, 1));
            default: s = ($urandom_range(0, 3) != 0);
          endcase
          out_stall_i <= s;
          @(posedge clk_i);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus and end of run
  initial begin : stim
    int unsigned i, r, s;
    logic [SEQ_W-1:0] seq;
    // base walks 0 -> 1 -> 5 -> 1 -> 2
    dir_rows = '{
      '{3'd5, 1'b0, 32'hffff_ffff, EXP_NONE},      // corrupted, nothing
      '{3'd0, 1'b1, 32'h0000_0000, EXP_ACK_DLV},   // base hit after reset
      '{3'd0, 1'b1, 32'h1111_1111, EXP_ACK},       // just below base: re-ack
      '{3'd5, 1'b1, 32'h2222_2222, EXP_ACK},       // far end of previous window
      '{3'd2, 1'b1, 32'hffff_ffff, EXP_ACK},       // held out of order
      '{3'd3, 1'b1, 32'ha5a5_a5a5, EXP_ACK},
      '{3'd3, 1'b1, 32'h5a5a_5a5a, EXP_ACK},       // duplicate, first copy kept
      '{3'd4, 1'b1, 32'h1234_5678, EXP_ACK},       // top of window
      '{3'd1, 1'b1, 32'h8000_0000, EXP_PREDICTED}, // full flush of the window
      '{3'd6, 1'b1, 32'h7fff_ffff, EXP_ACK},
      '{3'd7, 1'b1, 32'h0000_0001, EXP_ACK},
      '{3'd0, 1'b1, 32'hcafe_f00d, EXP_ACK},       // window wraps past zero
      '{3'd5, 1'b0, 32'h0000_0000, EXP_NONE},      // corrupted base hit
      '{3'd5, 1'b1, 32'hdead_beef, EXP_PREDICTED}, // flush across the wrap
      '{3'd1, 1'b1, 32'h0000_0000, EXP_ACK_DLV},
      '{3'd7, 1'b0, 32'hffff_ffff, EXP_NONE},
      '{3'd7, 1'b1, 32'h0f0f_0f0f, EXP_PREDICTED}  // previous window below base
    };
    win_base = 0;
    for (i = 0; i < SEQ_COUNT; i++) begin
      slot_held[i] = 1'b0;
      slot_data[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < N_DIR; i++)
      offer_packet(dir_rows[i].seq, dir_rows[i].ok, dir_rows[i].payload, dir_rows[i].mode);

    // random stream, mostly inside the receive window
    for (i = 0; i < RAND_PKTS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65)
        s = (win_base + $urandom_range(0, WINDOW - 1)) % SEQ_COUNT;
      else if (r < 85)
        s = (win_base + SEQ_COUNT - $urandom_range(1, WINDOW)) % SEQ_COUNT;
      else
        s = $urandom_range(0, SEQ_COUNT - 1);
      seq = SEQ_W'(s);
      offer_packet(seq, ($urandom_range(0, 9) != 0), PAYLOAD_BITS'($urandom()),
                   EXP_PREDICTED);
    end
    in_valid_i <= 1'b0;

    // drain, then give stray results a chance to show up
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/srrw_pkg.sv
hdl/srrw_mem.sv
hdl/selective_repeat_receiver_window.sv
bench/selective_repeat_receiver_window_tb.sv
